// File: sv/railcom_address_receiver_unit_macros.svh
// Assertion macros used by the receiver top module.
`ifndef RAILCOM_ADDRESS_RECEIVER_UNIT_MACROS_SVH
`define RAILCOM_ADDRESS_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rar_pkg.sv
`timescale 1ns / 1ps

package rar_pkg;

  // Default sizes of the address history and the frame buffer.
  localparam int HISTORY_DEPTH_DEF = 2;
  localparam int FRAME_SLOTS_DEF   = 4;

  // Reset value of the view timeout limit, in ticks.
  localparam logic [15:0] VIEW_LIMIT_RESET = 16'd1000;

  // Line codes that close a frame.
  localparam logic [7:0] CODE_NACK = 8'h0F;
  localparam logic [7:0] CODE_ACK  = 8'hF0;
  localparam logic [7:0] CODE_BUSY = 8'hE1;

  // Datagram identifiers.
  localparam logic [3:0] ID_LONG_ADDR  = 4'd1;
  localparam logic [3:0] ID_SHORT_ADDR = 4'd2;

  // Top two data bits that mark the long-address high part.
  localparam logic [1:0] LONG_ADDR_TAG = 2'b10;

  // Step commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        show_update;
    logic [15:0] shown_address;
    logic        timed_out;
  } out_item_t;

  // A decoded line byte: a 6-bit symbol, or a code that closes the frame.
  typedef struct packed {
    logic       is_data;
    logic [5:0] value;
  } sym_t;

  // What the frame buffer reports on a byte transfer.
  typedef struct packed {
    logic       pair_closed;
    logic [5:0] sym0;
    logic [5:0] sym1;
  } frame_evt_t;

  // 4-of-8 code table, indexed by symbol value.
  localparam logic [7:0] CODE_TABLE [64] = '{
    8'hAC, 8'hAA, 8'hA9, 8'hA5, 8'hA3, 8'hA6, 8'h9C, 8'h9A,
    8'h99, 8'h95, 8'h93, 8'h96, 8'h8E, 8'h8D, 8'h8B, 8'hB1,
    8'hB2, 8'hB4, 8'hB8, 8'h74, 8'h72, 8'h6C, 8'h6A, 8'h69,
    8'h65, 8'h63, 8'h66, 8'h5C, 8'h5A, 8'h59, 8'h55, 8'h53,
    8'h56, 8'h4E, 8'h4D, 8'h4B, 8'h47, 8'h71, 8'hE8, 8'hE4,
    8'hE2, 8'hD1, 8'hC9, 8'hC5, 8'hD8, 8'hD4, 8'hD2, 8'hCA,
    8'hC6, 8'hCC, 8'h78, 8'h17, 8'h1B, 8'h1D, 8'h1E, 8'h2E,
    8'h36, 8'h3A, 8'h27, 8'h2B, 8'h2D, 8'h35, 8'h39, 8'h33
  };

  // Reverse lookup of a line byte. Closing codes and bytes that are not in
  // the table both come back as non-data.
  function automatic sym_t map_byte(input logic [7:0] b);
    sym_t res;
    res = '0;
    for (int k = 0; k < 64; k++) begin
      if (CODE_TABLE[k] == b) begin
        res.is_data = 1'b1;
        res.value   = 6'(k);
      end
    end
    if (b == CODE_NACK || b == CODE_ACK || b == CODE_BUSY) begin
      res.is_data = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: sv/rar_frame_buf.sv
`timescale 1ns / 1ps

module rar_frame_buf
  import rar_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  output frame_evt_t evt
);

  localparam int FILL_W = $clog2(FRAME_SLOTS + 1);
  localparam int IDX_W  = $clog2(FRAME_SLOTS);

  logic [5:0]        slot_r [FRAME_SLOTS];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  sym_t              sym;
  logic              has_room;

  assign sym      = map_byte(rx_byte);
  assign has_room = (fill_r < FILL_W'(FRAME_SLOTS));

  // A closing byte reports whether exactly two symbols were collected.
  assign evt.pair_closed = byte_en && !sym.is_data && (fill_r == FILL_W'(2));
  assign evt.sym0        = slot_r[0];
  assign evt.sym1        = slot_r[1];

  // Fill count: cleared on close, advanced on a stored symbol.
  always_comb begin
    fill_nxt = fill_r;
    if (byte_en) begin
      if (!sym.is_data) begin
        fill_nxt = '0;
      end else if (has_room) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Symbol slots hold payload only; a full frame drops further symbols.
  always_ff @(posedge clk) begin
    if (byte_en && sym.is_data && has_room) begin
      slot_r[fill_r[IDX_W-1:0]] <= sym.value;
    end
  end

endmodule

// File: sv/rar_addr_track.sv
`timescale 1ns / 1ps

module rar_addr_track
  import rar_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_evt_t  evt,
  output logic        confirmed,
  output logic [15:0] address
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [15:0]      addr_r;
  logic [15:0]      addr_nxt;
  logic [15:0]      hist_r [HISTORY_DEPTH];
  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] ptr_nxt;
  logic [3:0]       id;
  logic [7:0]       data;
  logic             long_step;
  logic             all_equal;

  assign id        = evt.sym0[5:2];
  assign data      = {evt.sym0[1:0], evt.sym1};
  assign long_step = evt.pair_closed && (id == ID_LONG_ADDR);

  // New assembled address for this transfer.
  always_comb begin
    addr_nxt = addr_r;
    if (long_step) begin
      if (data[7:6] == LONG_ADDR_TAG) begin
        addr_nxt = addr_r + {2'b00, data[5:0], 8'h00};
      end
    end else if (evt.pair_closed && (id == ID_SHORT_ADDR)) begin
      addr_nxt = {8'h00, data};
    end
  end

  // The address is confirmed when every history entry already holds it.
  always_comb begin
    all_equal = 1'b1;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (hist_r[k] != addr_nxt) begin
        all_equal = 1'b0;
      end
    end
  end

  assign confirmed = long_step && all_equal;
  assign address   = addr_nxt;

  // History pointer wraps at the history depth.
  always_comb begin
    ptr_nxt = ptr_r;
    if (long_step) begin
      if (ptr_r == PTR_W'(HISTORY_DEPTH - 1)) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      ptr_r  <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      addr_r <= addr_nxt;
      ptr_r  <= ptr_nxt;
      if (long_step) begin
        hist_r[ptr_r] <= addr_nxt;
      end
    end
  end

endmodule

// File: sv/railcom_address_receiver_unit.sv
// Path: an accepted transfer is held in the input register, decoded from there, and its
// result is registered in the output register.
// Throughput: one item per cycle while out_stall is low, set by the single decode stage behind the input register.
// The output register keeps a result while the input register takes the next item.
// Reset (rst_n low, synchronous): frame, address, history and view timer cleared,
// view timeout limit loaded with 1000, both channels empty.
`timescale 1ns / 1ps
`include "railcom_address_receiver_unit_macros.svh"

module railcom_address_receiver_unit
  import rar_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int FRAME_SLOTS   = FRAME_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        s1_valid_r;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   result;
  logic        advance;
  logic        fire;
  logic        byte_en;
  logic [15:0] limit_r;
  logic [15:0] timer_r;
  logic [15:0] timer_nxt;
  frame_evt_t  evt;
  logic        confirmed;
  logic [15:0] address;

  // The decode stage moves whenever the output register is free or drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign fire     = s1_valid_r && advance;
  assign byte_en  = fire && (s1_data_r.command == CMD_BYTE);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= VIEW_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  rar_frame_buf #(
    .FRAME_SLOTS(FRAME_SLOTS)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_en(byte_en),
    .rx_byte(s1_data_r.rx_byte),
    .evt    (evt)
  );

  rar_addr_track #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .confirmed(confirmed),
    .address  (address)
  );

  // View timer: a tick advances it up to one past the limit, a confirmed
  // address clears it, and it never wraps.
  always_comb begin
    timer_nxt = timer_r;
    if (fire) begin
      if (s1_data_r.command == CMD_TICK) begin
        if (timer_r <= limit_r && timer_r != 16'hFFFF) begin
          timer_nxt = timer_r + 16'd1;
        end
      end else if (confirmed) begin
        timer_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else begin
      timer_r <= timer_nxt;
    end
  end

  // Result of this transfer, taken after the state update.
  always_comb begin
    result.show_update   = confirmed;
    result.shown_address = confirmed ? address : 16'h0000;
    result.timed_out     = (timer_nxt > limit_r);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A confirmed address has just cleared the timer, so it cannot be timed out.
  `RAR_ASSERT_SAME(a_show_not_timed_out, out_valid && out_data.show_update,
                   !out_data.timed_out, "confirmed address reported as timed out")

  // Without a display update the address field reads zero.
  `RAR_ASSERT_SAME(a_idle_address_zero, out_valid && !out_data.show_update,
                   out_data.shown_address == 16'h0000, "address shown without update")

  // An accepted input transfer always lands in the decode stage.
  `RAR_ASSERT_NEXT(a_accept_loads_stage, in_valid && !in_stall,
                   s1_valid_r, "accepted transfer lost at the input register")

endmodule
